FILE: src/klv_track_demux_assert.svh
// Assertion helpers for the KLV track demultiplexer.
`ifndef KLV_TRACK_DEMUX_ASSERT_SVH
`define KLV_TRACK_DEMUX_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define KLVD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("klvd assertion failed");
// Condition must never be seen outside reset.
`define KLVD_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("klvd forbidden condition seen");
`else
`define KLVD_ASSERT(label, clk, rst_n, prop)
`define KLVD_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

FILE: src/klvd_pkg.sv
`timescale 1ns / 1ps
package klvd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned TrackW    = 32;
  localparam int unsigned LenW      = 24;
  localparam int unsigned KeyUpperW = 64;
  localparam int unsigned KeyLowerW = 32;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 64;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [ByteW-1:0] RunInEnd     = 8'd6;
  localparam logic [3:0]       KeyMatchLast = 4'd11;
  localparam logic [3:0]       KeyLastPos   = 4'd15;
  localparam logic [1:0]       LenLastPos   = 2'd3;

  localparam logic [KeyUpperW-1:0] KeyUpperReset = 64'h060E_2B34_0102_0101;
  localparam logic [KeyLowerW-1:0] KeyLowerReset = 32'h0D01_0301;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegKeyUpper = 8'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLower = 8'd1;

  // Parse phases
  localparam logic [1:0] PhSeek  = 2'd0;
  localparam logic [1:0] PhKey   = 2'd1;
  localparam logic [1:0] PhLen   = 2'd2;
  localparam logic [1:0] PhValue = 2'd3;

  typedef struct packed {
    logic [TrackW-1:0] track_id;
    logic [ByteW-1:0]  payload_byte;
    logic              last_of_packet;
  } klvd_rec_t;

  // Key byte at position pos (0 to 11), first byte most significant
  function automatic logic [ByteW-1:0] key_byte(input logic [KeyUpperW-1:0] upper,
                                                input logic [KeyLowerW-1:0] lower,
                                                input logic [3:0] pos);
    logic [KeyUpperW+KeyLowerW-1:0] key;
    logic [6:0]                     base;
    key  = {upper, lower};
    base = 7'(88 - 8 * int'(pos));
    return key[base +: ByteW];
  endfunction

endpackage

FILE: src/klvd_if.sv
`timescale 1ns / 1ps
interface klvd_byte_if import klvd_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] stream_byte;

  modport source(output valid, output stream_byte, input ready);
  modport sink(input valid, input stream_byte, output ready);
endinterface

interface klvd_out_if import klvd_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [TrackW-1:0] track_id;
  logic [ByteW-1:0]  payload_byte;
  logic              last_of_packet;

  modport source(output valid, output track_id, output payload_byte,
                 output last_of_packet, input ready);
  modport sink(input valid, input track_id, input payload_byte,
               input last_of_packet, output ready);
endinterface

interface klvd_cfg_if import klvd_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] reg_data;

  modport source(output valid, output reg_index, output reg_data, input ready);
  modport sink(input valid, input reg_index, input reg_data, output ready);
endinterface

FILE: src/klvd_parse.sv
`timescale 1ns / 1ps
`include "klv_track_demux_assert.svh"
module klvd_parse import klvd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  klvd_byte_if.sink    stream_i,
  klvd_cfg_if.sink     cfg_i,
  input  logic         space_i,
  output logic         push_o,
  output klvd_rec_t    rec_o
);

  logic [KeyUpperW-1:0] key_upper_q;
  logic [KeyLowerW-1:0] key_lower_q;
  logic [1:0]           phase_q, phase_d;
  logic [3:0]           pos_q, pos_d;
  logic                 match_q, match_d;
  logic [TrackW-1:0]    track_q, track_d;
  logic [LenW-1:0]      rem_q, rem_d;

  logic                 accept;
  logic [ByteW-1:0]     b;
  logic [1:0]           phase_v;
  logic [3:0]           pos_v;
  logic                 match_v;
  logic [TrackW-1:0]    track_v;
  logic [LenW-1:0]      rem_new;
  logic [LenW-1:0]      rem_dec;

  assign cfg_i.ready    = 1'b1;
  assign stream_i.ready = space_i;
  assign accept         = stream_i.valid & space_i;
  assign b              = stream_i.stream_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= KeyUpperReset;
      key_lower_q <= KeyLowerReset;
    end else if (cfg_i.valid) begin
      // writes beyond the register list are dropped
      if (cfg_i.reg_index == RegKeyUpper) begin
        key_upper_q <= cfg_i.reg_data;
      end else if (cfg_i.reg_index == RegKeyLower) begin
        key_lower_q <= cfg_i.reg_data[KeyLowerW-1:0];
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    match_d = match_q;
    track_d = track_q;
    rem_d   = rem_q;
    push_o  = 1'b0;
    rec_o   = '{track_id: track_q, payload_byte: b, last_of_packet: 1'b0};
    phase_v = phase_q;
    pos_v   = pos_q;
    match_v = match_q;
    track_v = track_q;
    rem_new = rem_q;
    rem_dec = rem_q - LenW'(1);
    if (accept) begin
      // the run-in end byte is itself the first key byte
      if (phase_q == PhSeek && b == RunInEnd) begin
        phase_v = PhKey;
        pos_v   = '0;
        match_v = 1'b1;
        track_v = '0;
      end
      unique case (phase_v)
        PhSeek: begin
        end
        PhKey: begin
          phase_d = phase_v;
          match_d = match_v;
          track_d = track_v;
          if (pos_v <= KeyMatchLast) begin
            match_d = match_v & (b == key_byte(key_upper_q, key_lower_q, pos_v));
          end else begin
            unique case (pos_v[1:0])
              2'd0:    track_d[7:0]   = b;
              2'd1:    track_d[15:8]  = b;
              2'd2:    track_d[23:16] = b;
              default: track_d[31:24] = b;
            endcase
          end
          if (pos_v == KeyLastPos) begin
            phase_d = PhLen;
            pos_d   = '0;
            rem_d   = '0;
          end else begin
            pos_d = pos_v + 4'd1;
          end
        end
        PhLen: begin
          // first length byte is ignored
          if (pos_v[1:0] != 2'd0) begin
            rem_new = {rem_q[LenW-ByteW-1:0], b};
          end
          rem_d = rem_new;
          if (pos_v[1:0] == LenLastPos) begin
            if (rem_new == '0) begin
              phase_d = PhKey;
              pos_d   = '0;
              match_d = 1'b1;
              track_d = '0;
            end else begin
              phase_d = PhValue;
            end
          end else begin
            pos_d = pos_v + 4'd1;
          end
        end
        default: begin
          rem_d  = rem_dec;
          push_o = match_q;
          rec_o  = '{track_id: track_q, payload_byte: b,
                     last_of_packet: (rem_dec == '0)};
          if (rem_dec == '0) begin
            phase_d = PhKey;
            pos_d   = '0;
            match_d = 1'b1;
            track_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSeek;
      pos_q   <= '0;
      match_q <= 1'b1;
      track_q <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      match_q <= match_d;
      track_q <= track_d;
      rem_q   <= rem_d;
    end
  end

  `KLVD_ASSERT(a_push_in_value, clk_i, rst_ni, push_o |-> (phase_q == PhValue))
  `KLVD_ASSERT(a_last_restarts_key, clk_i, rst_ni,
               (push_o && rec_o.last_of_packet) |=> (phase_q == PhKey && pos_q == 4'd0))

endmodule

FILE: src/klvd_queue.sv
`timescale 1ns / 1ps
`include "klv_track_demux_assert.svh"
module klvd_queue import klvd_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  klvd_rec_t rec_i,
  output logic      space_o,
  input  logic      pop_i,
  output klvd_rec_t rec_o,
  output logic      avail_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  klvd_rec_t           entries_q [Depth];
  logic [IdxW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign space_o = (cnt_q != CntW'(Depth));
  assign avail_o = (cnt_q != '0);
  assign do_push = push_i & space_o;
  assign do_pop  = pop_i & avail_o;
  assign rec_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `KLVD_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && !space_o)
  `KLVD_ASSERT(a_cnt_bounded, clk_i, rst_ni, cnt_q <= CntW'(Depth))

endmodule

FILE: src/klvd_emit.sv
`timescale 1ns / 1ps
module klvd_emit import klvd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       avail_i,
  input  klvd_rec_t  rec_i,
  output logic       pop_o,
  klvd_out_if.source result_o
);

  logic      valid_q, valid_d;
  klvd_rec_t rec_q;

  // load the output register whenever it is empty or being drained
  assign pop_o   = avail_i & (~valid_q | result_o.ready);
  assign valid_d = pop_o | (valid_q & ~result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= rec_i;
    end
  end

  assign result_o.valid          = valid_q;
  assign result_o.track_id       = rec_q.track_id;
  assign result_o.payload_byte   = rec_q.payload_byte;
  assign result_o.last_of_packet = rec_q.last_of_packet;

endmodule

FILE: src/klv_track_demux.sv
`timescale 1ns / 1ps
// KLV track demultiplexer: takes one container byte per cycle and passes on the
// value bytes of packets whose first twelve key bytes match the configured key,
// each tagged with the track id from the last four key bytes and a last-byte
// flag. Bytes before the first 0x06 after reset are dropped; once parsing has
// begun there is no resynchronisation. A byte is accepted every cycle while the
// result queue has room. Its result is written into the queue at the edge that
// takes the byte and moves into the output register once that register is empty
// or being drained, from where it is offered on the result channel. Only a
// stalled result channel slows the input, once the queue of QueueDepth entries
// has filled. Key registers may be written only while no packet byte is in
// flight.
module klv_track_demux import klvd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  klvd_byte_if.sink  stream_i,
  klvd_cfg_if.sink   cfg_i,
  klvd_out_if.source result_o
);

  logic      push;
  logic      space;
  logic      pop;
  logic      avail;
  klvd_rec_t front_rec;
  klvd_rec_t back_rec;

  klvd_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stream_i (stream_i),
    .cfg_i    (cfg_i),
    .space_i  (space),
    .push_o   (push),
    .rec_o    (front_rec)
  );

  klvd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .space_o (space),
    .pop_i   (pop),
    .rec_o   (back_rec),
    .avail_o (avail)
  );

  klvd_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .avail_i  (avail),
    .rec_i    (back_rec),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

FILE: sim/klv_track_demux_tb.sv
`timescale 1ns / 1ps
module klv_track_demux_tb;
  import klvd_pkg::*;

  localparam int unsigned CycleLimit   = 3_000_000;
  localparam int unsigned DrainLimit   = 2000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PrintLimit   = 50;

  // Indexes past the register list; writes to them must change nothing
  localparam logic [CfgIdxW-1:0] RegBeyond = RegKeyLower + 8'd1;
  localparam logic [CfgIdxW-1:0] RegTopIdx = '1;

  typedef enum logic [1:0] {RowRunIn, RowMatch, RowMiss} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [ByteW-1:0]  val;
    int unsigned       miss_at;
    logic [TrackW-1:0] track;
    logic [ByteW-1:0]  len_top;
    logic [LenW-1:0]   len;
    bit                typed;
    bit                exp_some;
    klvd_rec_t         exp;
  } row_t;

  logic clk_i;
  logic rst_ni;

  klvd_byte_if stream_if ();
  klvd_cfg_if  cfg_if ();
  klvd_out_if  result_if ();

  klv_track_demux uut (
    .clk_i,
    .rst_ni,
    .stream_i(stream_if),
    .cfg_i   (cfg_if),
    .result_o(result_if)
  );

  // Typed rows expect either nothing or the single record given here
  row_t directed_rows [14] = '{
    '{RowRunIn, 8'h00, 0, 32'h0, 8'h00, 24'd0, 1'b1, 1'b0, '0},
    '{RowRunIn, 8'hFF, 0, 32'h0, 8'h00, 24'd0, 1'b1, 1'b0, '0},
    '{RowRunIn, 8'h07, 0, 32'h0, 8'h00, 24'd0, 1'b1, 1'b0, '0},
    '{RowRunIn, 8'h05, 0, 32'h0, 8'h00, 24'd0, 1'b1, 1'b0, '0},
    '{RowMatch, 8'h00, 0, 32'h0000_0000, 8'hFF, 24'd1, 1'b1, 1'b1,
      {32'h0000_0000, 8'h00, 1'b1}},
    '{RowMatch, 8'hFF, 0, 32'hFFFF_FFFF, 8'h00, 24'd1, 1'b1, 1'b1,
      {32'hFFFF_FFFF, 8'hFF, 1'b1}},
    '{RowMatch, 8'h00, 0, 32'h0000_0001, 8'h5A, 24'd0, 1'b1, 1'b0, '0},
    '{RowMiss,  8'h11, 0, 32'h0000_0002, 8'h00, 24'd3, 1'b1, 1'b0, '0},
    '{RowMiss,  8'h22, 11, 32'h0000_0003, 8'h00, 24'd2, 1'b1, 1'b0, '0},
    '{RowMiss,  8'h00, 5, 32'h0000_0004, 8'hFF, 24'd0, 1'b1, 1'b0, '0},
    '{RowMatch, 8'h80, 0, 32'h1234_5678, 8'h01, 24'd5, 1'b0, 1'b0, '0},
    '{RowMatch, 8'h00, 0, 32'h0000_00A5, 8'h00, 24'h00_0102, 1'b0, 1'b0, '0},
    '{RowMiss,  8'h33, 7, 32'h0000_0005, 8'h80, 24'h00_0040, 1'b1, 1'b0, '0},
    '{RowMatch, 8'h06, 0, 32'h8000_0001, 8'hAA, 24'd2, 1'b0, 1'b0, '0}
  };

  // Predictor state
  logic [KeyUpperW-1:0] key_upper_m;
  logic [KeyLowerW-1:0] key_lower_m;
  logic [1:0]           phase_m;
  logic [3:0]           pos_m;
  bit                   match_m;
  logic [TrackW-1:0]    track_m;
  logic [LenW-1:0]      left_m;

  klvd_rec_t   pending_payload[$];
  int unsigned bad_fields = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned rx_hold = 0;
  bit          quiet = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void open_key();
    phase_m = PhKey;
    pos_m   = '0;
    match_m = 1'b1;
    track_m = '0;
  endfunction

  // Advance the parser by one byte; return 1 when a payload record results
  function automatic bit demux_byte(input logic [ByteW-1:0] b, output klvd_rec_t rec);
    logic [KeyUpperW+KeyLowerW-1:0] key;
    bit                             last;
    bit                             emit;
    key = {key_upper_m, key_lower_m};
    rec = '0;
    if (phase_m == PhSeek) begin
      if (b != RunInEnd) return 1'b0;
      open_key();
    end
    case (phase_m)
      PhKey: begin
        if (pos_m <= KeyMatchLast) begin
          if (b != key[8*(11 - int'(pos_m)) +: 8]) match_m = 1'b0;
        end else begin
          track_m[8*(int'(pos_m) - int'(KeyMatchLast) - 1) +: 8] = b;
        end
        if (pos_m == KeyLastPos) begin
          phase_m = PhLen;
          pos_m   = '0;
          left_m  = '0;
        end else begin
          pos_m = pos_m + 1'b1;
        end
        return 1'b0;
      end
      PhLen: begin
        // first length byte carries nothing
        if (pos_m != '0) left_m = {left_m[LenW-9:0], b};
        if (pos_m == {2'b00, LenLastPos}) begin
          if (left_m == '0) open_key();
          else phase_m = PhValue;
        end else begin
          pos_m = pos_m + 1'b1;
        end
        return 1'b0;
      end
      default: begin
        left_m = left_m - 1'b1;
        last   = (left_m == '0);
        emit   = match_m;
        rec    = '{track_id: track_m, payload_byte: b, last_of_packet: last};
        if (last) open_key();
        return emit;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    bad_fields++;
    if (bad_fields <= PrintLimit) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic push_stream_byte(input logic [ByteW-1:0] b, input bit modelled);
    klvd_rec_t rec;
    bit        got;
    int unsigned gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      stream_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    stream_if.valid       <= 1'b1;
    stream_if.stream_byte <= b;
    do @(posedge clk_i); while (!stream_if.ready);
    sent++;
    got = demux_byte(b, rec);
    if (got && modelled) pending_payload.push_back(rec);
  endtask

  task automatic send_packet(input bit key_ok, input int unsigned miss_at,
                             input logic [TrackW-1:0] track, input logic [ByteW-1:0] len_top,
                             input logic [LenW-1:0] len, input logic [ByteW-1:0] first_val,
                             input bit rand_vals, input bit modelled);
    logic [KeyUpperW+KeyLowerW-1:0] key;
    logic [ByteW-1:0]               kb;
    key = {key_upper_m, key_lower_m};
    for (int i = 0; i < 12; i++) begin
      kb = key[8*(11 - i) +: 8];
      if (!key_ok && i == miss_at) kb = kb ^ 8'($urandom_range(1, 255));
      push_stream_byte(kb, modelled);
    end
    for (int i = 0; i < 4; i++) push_stream_byte(track[8*i +: 8], modelled);
    push_stream_byte(len_top, modelled);
    push_stream_byte(len[23:16], modelled);
    push_stream_byte(len[15:8], modelled);
    push_stream_byte(len[7:0], modelled);
    for (int unsigned i = 0; i < len; i++)
      push_stream_byte(rand_vals ? 8'($urandom) : first_val + 8'(i), modelled);
  endtask

  task automatic write_key_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.reg_data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == RegKeyUpper) key_upper_m = data;
    else if (idx == RegKeyLower) key_lower_m = data[KeyLowerW-1:0];
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Hold the stream until every pending record is back, then let the pipe empty
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    stream_if.valid <= 1'b0;
    while (pending_payload.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending_payload.size() != 0) begin
      report_mismatch($sformatf("%0d records never arrived", pending_payload.size()));
      pending_payload.delete();
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned      start;
    int unsigned      pick;
    int unsigned      lsel;
    logic [LenW-1:0]  len;
    logic [TrackW-1:0] track;
    start = sent;
    while (sent - start < n_bytes) begin
      pick = $urandom_range(0, 19);
      lsel = $urandom_range(0, 19);
      if (pick == 3)      len = '0;
      else if (lsel < 14) len = LenW'($urandom_range(1, 8));
      else if (lsel < 19) len = LenW'($urandom_range(9, 40));
      else                len = LenW'($urandom_range(100, 300));
      track = ($urandom_range(0, 3) == 0) ? TrackW'($urandom_range(0, 7)) : TrackW'($urandom);
      send_packet(pick > 2, $urandom_range(0, 11), track, 8'($urandom), len, 8'h00,
                  1'b1, 1'b1);
    end
  endtask

  // Drop ready in random bursts unless the run is in its quiet stretch
  always @(negedge clk_i) begin
    if (rx_hold == 0 && !quiet && $urandom_range(0, 5) == 0) rx_hold = $urandom_range(1, 9);
    if (rx_hold != 0) begin
      result_if.ready <= 1'b0;
      rx_hold--;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    klvd_rec_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_payload.size() == 0) begin
        report_mismatch($sformatf("unexpected record track %h byte %h",
                                  result_if.track_id, result_if.payload_byte));
      end else begin
        want = pending_payload.pop_front();
        if (result_if.track_id !== want.track_id)
          report_mismatch($sformatf("track_id %h, want %h", result_if.track_id,
                                    want.track_id));
        if (result_if.payload_byte !== want.payload_byte)
          report_mismatch($sformatf("payload_byte %h, want %h", result_if.payload_byte,
                                    want.payload_byte));
        if (result_if.last_of_packet !== want.last_of_packet)
          report_mismatch($sformatf("last_of_packet %b, want %b",
                                    result_if.last_of_packet, want.last_of_packet));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_t row;
    rst_ni                = 1'b0;
    stream_if.valid       = 1'b0;
    stream_if.stream_byte = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.reg_index      = '0;
    cfg_if.reg_data       = '0;
    result_if.ready       = 1'b0;
    key_upper_m           = KeyUpperReset;
    key_lower_m           = KeyLowerReset;
    phase_m               = PhSeek;
    pos_m                 = '0;
    match_m               = 1'b1;
    track_m               = '0;
    left_m                = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Writes past the list must leave the default key in place
    write_key_reg(RegBeyond, '1);
    write_key_reg(RegTopIdx, 64'h0123_4567_89AB_CDEF);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.typed && row.exp_some) pending_payload.push_back(row.exp);
      if (row.kind == RowRunIn)
        push_stream_byte(row.val, !row.typed);
      else
        send_packet(row.kind == RowMatch, row.miss_at, row.track, row.len_top, row.len,
                    row.val, 1'b0, !row.typed);
    end
    random_traffic(125);
    drain_results();

    write_key_reg(RegKeyUpper, '0);
    write_key_reg(RegKeyLower, 64'hFFFF_FFFF_0000_0000);
    random_traffic(125);
    drain_results();

    write_key_reg(RegKeyUpper, '1);
    write_key_reg(RegKeyLower, 64'h0000_0000_FFFF_FFFF);
    random_traffic(125);
    drain_results();

    write_key_reg(RegKeyUpper, {$urandom, $urandom});
    write_key_reg(RegKeyLower, {$urandom, $urandom});
    write_key_reg(RegBeyond, {$urandom, $urandom});
    quiet = 1'b1;
    random_traffic(200);
    drain_results();

    if (bad_fields == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
